/* hdl/assert_macros.svh */
// Assertion macros for the checker file of the drive command safety gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DCSG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DCSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dcsg_pkg.sv */
// Types, codes and helper functions for the drive command safety gate.
package dcsg_pkg;

    localparam int TIME_BITS = 32;

    localparam logic [15:0] ESTOP_TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] STALE_RESET         = 16'd300;
    localparam logic [6:0]  MAX_THR_RESET       = 7'd100;
    localparam logic [6:0]  BRAKE_THR_RESET     = 7'd20;

    localparam logic [6:0]  PCT_FULL       = 7'd100;
    localparam logic [7:0]  STEER_FULL     = 8'd100;
    // floor(x / 10) as (x * DIV10_RECIP) >> 16, exact for x below 2000
    localparam logic [23:0] DIV10_RECIP    = 24'd6554;
    localparam logic [10:0] SERVO_PER_STEP = 11'd9;

    // configuration register indexes
    localparam logic [1:0] CFG_ESTOP_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_CMD_STALE     = 2'd1;
    localparam logic [1:0] CFG_MAX_THROTTLE  = 2'd2;
    localparam logic [1:0] CFG_BRAKE_THRESH  = 2'd3;

    // requested modes carried by a control frame
    localparam logic [2:0] MODE_MANUAL    = 3'd1;
    localparam logic [2:0] MODE_LANE_KEEP = 3'd2;
    localparam logic [2:0] MODE_CRUISE    = 3'd3;
    localparam logic [2:0] MODE_ADAPTIVE  = 3'd4;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_CHECK = 2'd1,
        OP_CTRL  = 2'd2,
        OP_ESTOP = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_STOP = 2'd1,
        ACT_FWD  = 2'd2,
        ACT_BACK = 2'd3
    } motor_act_t;

    typedef enum logic [1:0] {
        IND_NONE  = 2'd0,
        IND_ALERT = 2'd1,
        IND_OFF   = 2'd2
    } indicator_t;

    typedef enum logic [1:0] {
        DM_IDLE   = 2'd0,
        DM_MANUAL = 2'd1,
        DM_AUTO   = 2'd2
    } drive_mode_t;

    typedef struct packed {
        opcode_t           opcode;
        logic              frame_ok;
        logic [2:0]        cmd_mode;
        logic signed [7:0] cmd_throttle;
        logic signed [7:0] cmd_steering;
        logic              brake_request;
        logic              estop_set;
        logic              brake_latch_active;
        logic [7:0]        brake_speed_limit;
        logic [7:0]        range_speed_limit;
        logic              cruise_active;
    } item_t;

    typedef struct packed {
        motor_act_t        motor_action;
        logic [6:0]        motor_duty;
        logic              servo_update;
        logic [7:0]        servo_deg;
        logic signed [7:0] throttle_now;
        logic signed [7:0] steering_now;
        drive_mode_t       drive_mode_out;
        logic              emergency_latched;
        indicator_t        indicator_action;
        logic              aeb_reset_request;
        logic              cruise_override;
    } result_t;

    function automatic logic signed [7:0] clamp100(input logic signed [7:0] v);
        logic signed [7:0] r;
        r = v;
        if (v < -$signed(STEER_FULL))
        begin
            r = -$signed(STEER_FULL);
        end
        else if (v > $signed(STEER_FULL))
        begin
            r = $signed(STEER_FULL);
        end
        return r;
    endfunction

    // smaller of a 7-bit limit and an 8-bit limit; fits 7 bits
    function automatic logic [6:0] min_lim(input logic [6:0] a, input logic [7:0] b);
        logic [6:0] r;
        r = a;
        if (b < {1'b0, a})
        begin
            r = b[6:0];
        end
        return r;
    endfunction

    // servo angle = (100 - steering) * 180 / 200, steering already clamped
    function automatic logic [7:0] servo_deg_f(input logic signed [7:0] steer);
        logic [7:0]  diff;
        logic [10:0] scaled;
        logic [23:0] prod;
        diff   = STEER_FULL - steer;
        scaled = 11'(diff) * SERVO_PER_STEP;
        prod   = 24'(scaled) * DIV10_RECIP;
        return prod[23:16];
    endfunction

endpackage

/* hdl/drive_command_safety_gate.sv */
// Top level of the drive command safety gate: item register, decision logic, result register.

// Drive command safety gate. Every accepted item (millisecond tick, periodic
// check, control frame or emergency frame) yields exactly one result item.
// The gate takes one item per clock cycle while in_stall is low; an accepted
// item lands in the item register, is decided by one stage of logic against
// the live state (timer, emergency latch, last command time, applied throttle
// and steering, drive mode) and moves into the result register once that
// register is free or is being emptied. A single decision stage lies between
// the item register and the result register. While a result is held by
// out_stall, one more item still enters and waits in the item register;
// in_stall rises only when both registers are full.
// Configuration registers are plain writes through cfg_we/cfg_index/cfg_wdata
// and are meant to change only while the gate is idle. All time arithmetic
// wraps at TIME_BITS.
module drive_command_safety_gate
    import dcsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic              frame_ok,
    input  logic [2:0]        cmd_mode,
    input  logic signed [7:0] cmd_throttle,
    input  logic signed [7:0] cmd_steering,
    input  logic              brake_request,
    input  logic              estop_set,
    input  logic              brake_latch_active,
    input  logic [7:0]        brake_speed_limit,
    input  logic [7:0]        range_speed_limit,
    input  logic              cruise_active,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        motor_action,
    output logic [6:0]        motor_duty,
    output logic              servo_update,
    output logic [7:0]        servo_deg,
    output logic signed [7:0] throttle_now,
    output logic signed [7:0] steering_now,
    output logic [1:0]        drive_mode_out,
    output logic              emergency_latched,
    output logic [1:0]        indicator_action,
    output logic              aeb_reset_request,
    output logic              cruise_override
);

    // configuration
    logic [15:0] estop_timeout_reg;
    logic [15:0] cmd_stale_reg;
    logic [6:0]  max_throttle_reg;
    logic [6:0]  brake_thresh_reg;

    // gate state
    logic [TIME_BITS-1:0] time_reg,      time_next;
    logic                 em_flag_reg,   em_flag_next;
    logic [TIME_BITS-1:0] em_since_reg,  em_since_next;
    logic [TIME_BITS-1:0] last_cmd_reg,  last_cmd_next;
    logic                 cmd_seen_reg,  cmd_seen_next;
    logic signed [7:0]    thr_reg,       thr_next;
    logic signed [7:0]    steer_reg,     steer_next;
    drive_mode_t          dmode_reg,     dmode_next;

    // pipeline
    logic    item_valid_reg;
    item_t   item_reg;
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;

    logic    in_accept;
    logic    advance;

    // decision intermediates
    logic [TIME_BITS-1:0] em_age;
    logic [TIME_BITS-1:0] cmd_age;
    logic [6:0]           lim_global;
    logic [6:0]           lim_check;
    logic [6:0]           lim_ctrl;
    logic signed [7:0]    steer_c;
    logic signed [7:0]    thr_c;
    logic                 cruise_mode_req;
    logic                 em_live;
    logic signed [7:0]    thr_live;

    // Move an item on when the result register is free or is being emptied.
    assign advance   = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && res_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign em_age     = time_reg - em_since_reg;
    assign cmd_age    = time_reg - last_cmd_reg;
    assign lim_global = (max_throttle_reg > PCT_FULL) ? PCT_FULL : max_throttle_reg;
    assign lim_check  = min_lim(lim_global, item_reg.brake_speed_limit);
    assign lim_ctrl   = min_lim(min_lim(lim_global, item_reg.range_speed_limit),
                                item_reg.brake_speed_limit);
    assign steer_c    = clamp100(item_reg.cmd_steering);
    assign cruise_mode_req = (item_reg.cmd_mode == MODE_CRUISE) ||
                             (item_reg.cmd_mode == MODE_ADAPTIVE);

    always_comb
    begin
        time_next     = time_reg;
        em_flag_next  = em_flag_reg;
        em_since_next = em_since_reg;
        last_cmd_next = last_cmd_reg;
        cmd_seen_next = cmd_seen_reg;
        thr_next      = thr_reg;
        steer_next    = steer_reg;
        dmode_next    = dmode_reg;
        em_live       = em_flag_reg;
        thr_live      = thr_reg;
        thr_c         = clamp100(item_reg.cmd_throttle);

        res_next                   = '0;
        res_next.motor_action      = ACT_NONE;
        res_next.indicator_action  = IND_NONE;

        case (item_reg.opcode)
            OP_TICK:
            begin
                time_next = time_reg + TIME_BITS'(1);
            end
            OP_CHECK:
            begin
                // expire an emergency latch that nobody renewed
                if (em_flag_reg && (em_age >= TIME_BITS'(estop_timeout_reg)))
                begin
                    em_live                    = 1'b0;
                    em_since_next              = '0;
                    res_next.aeb_reset_request = 1'b1;
                    res_next.indicator_action  = IND_OFF;
                end
                // stop the motor on a stale command
                if (cmd_seen_reg && (cmd_age > TIME_BITS'(cmd_stale_reg)) && (thr_reg != 0))
                begin
                    res_next.motor_action = ACT_STOP;
                    thr_live              = '0;
                end
                // stop forward throttle under a latch; above the limit, stop it or cut it to the limit
                if ((em_live || item_reg.brake_latch_active) && (thr_live > 0))
                begin
                    res_next.motor_action = ACT_STOP;
                    thr_live              = '0;
                end
                else if ((thr_live > 0) && (thr_live[6:0] > lim_check))
                begin
                    if (lim_check < brake_thresh_reg)
                    begin
                        res_next.motor_action = ACT_STOP;
                        thr_live              = '0;
                    end
                    else
                    begin
                        res_next.motor_action = ACT_FWD;
                        res_next.motor_duty   = lim_check;
                        thr_live              = $signed({1'b0, lim_check});
                    end
                end
                em_flag_next = em_live;
                thr_next     = thr_live;
            end
            OP_ESTOP:
            begin
                if (item_reg.frame_ok)
                begin
                    if (item_reg.estop_set)
                    begin
                        em_flag_next              = 1'b1;
                        em_since_next             = time_reg;
                        res_next.motor_action     = ACT_STOP;
                        thr_next                  = '0;
                        steer_next                = '0;
                        res_next.indicator_action = IND_ALERT;
                    end
                    else
                    begin
                        em_flag_next               = 1'b0;
                        em_since_next              = '0;
                        res_next.aeb_reset_request = 1'b1;
                        res_next.indicator_action  = IND_OFF;
                    end
                end
            end
            OP_CTRL:
            begin
                if (item_reg.frame_ok)
                begin
                    last_cmd_next         = time_reg;
                    cmd_seen_next         = 1'b1;
                    res_next.servo_update = 1'b1;
                    res_next.servo_deg    = servo_deg_f(steer_c);
                    steer_next            = steer_c;

                    if (item_reg.cmd_mode == MODE_MANUAL)
                    begin
                        dmode_next = DM_MANUAL;
                    end
                    else if ((item_reg.cmd_mode == MODE_LANE_KEEP) || cruise_mode_req)
                    begin
                        dmode_next = DM_AUTO;
                    end
                    else
                    begin
                        dmode_next = DM_IDLE;
                    end

                    if (!cruise_mode_req && item_reg.cruise_active)
                    begin
                        res_next.cruise_override = 1'b1;
                    end

                    if (item_reg.brake_request)
                    begin
                        res_next.cruise_override = 1'b1;
                        res_next.motor_action    = ACT_STOP;
                        thr_next                 = '0;
                    end
                    else if ((item_reg.cmd_mode == MODE_MANUAL) ||
                             (item_reg.cmd_mode == MODE_LANE_KEEP))
                    begin
                        // block forward throttle under a latched stop
                        if ((em_flag_reg || item_reg.brake_latch_active) &&
                            !item_reg.cmd_throttle[7])
                        begin
                            res_next.motor_action = ACT_STOP;
                            thr_next              = '0;
                        end
                        else
                        begin
                            if (thr_c > $signed({1'b0, lim_ctrl}))
                            begin
                                thr_c = $signed({1'b0, lim_ctrl});
                            end
                            if (thr_c == 0)
                            begin
                                res_next.motor_action = ACT_STOP;
                            end
                            else if (thr_c > 0)
                            begin
                                res_next.motor_action = ACT_FWD;
                                res_next.motor_duty   = thr_c[6:0];
                            end
                            else
                            begin
                                res_next.motor_action = ACT_BACK;
                                res_next.motor_duty   = 7'(-thr_c);
                            end
                            thr_next = thr_c;
                        end
                    end
                    else if (!cruise_mode_req)
                    begin
                        res_next.motor_action = ACT_STOP;
                        thr_next              = '0;
                    end
                end
            end
            default:
            begin
                time_next = time_reg;
            end
        endcase

        res_next.throttle_now      = thr_next;
        res_next.steering_now      = steer_next;
        res_next.drive_mode_out    = dmode_next;
        res_next.emergency_latched = em_flag_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            estop_timeout_reg <= ESTOP_TIMEOUT_RESET;
            cmd_stale_reg     <= STALE_RESET;
            max_throttle_reg  <= MAX_THR_RESET;
            brake_thresh_reg  <= BRAKE_THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ESTOP_TIMEOUT: estop_timeout_reg <= cfg_wdata;
                CFG_CMD_STALE:     cmd_stale_reg     <= cfg_wdata;
                CFG_MAX_THROTTLE:  max_throttle_reg  <= cfg_wdata[6:0];
                CFG_BRAKE_THRESH:  brake_thresh_reg  <= cfg_wdata[6:0];
                default:           estop_timeout_reg <= estop_timeout_reg;
            endcase
        end
    end

    // state and handshake control; state moves only with an advancing item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            em_flag_reg    <= 1'b0;
            em_since_reg   <= '0;
            last_cmd_reg   <= '0;
            cmd_seen_reg   <= 1'b0;
            thr_reg        <= '0;
            steer_reg      <= '0;
            dmode_reg      <= DM_IDLE;
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                time_reg     <= time_next;
                em_flag_reg  <= em_flag_next;
                em_since_reg <= em_since_next;
                last_cmd_reg <= last_cmd_next;
                cmd_seen_reg <= cmd_seen_next;
                thr_reg      <= thr_next;
                steer_reg    <= steer_next;
                dmode_reg    <= dmode_next;
            end

            if (in_accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.opcode             <= opcode_t'(opcode);
            item_reg.frame_ok           <= frame_ok;
            item_reg.cmd_mode           <= cmd_mode;
            item_reg.cmd_throttle       <= cmd_throttle;
            item_reg.cmd_steering       <= cmd_steering;
            item_reg.brake_request      <= brake_request;
            item_reg.estop_set          <= estop_set;
            item_reg.brake_latch_active <= brake_latch_active;
            item_reg.brake_speed_limit  <= brake_speed_limit;
            item_reg.range_speed_limit  <= range_speed_limit;
            item_reg.cruise_active      <= cruise_active;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = res_valid_reg;
    assign motor_action      = res_reg.motor_action;
    assign motor_duty        = res_reg.motor_duty;
    assign servo_update      = res_reg.servo_update;
    assign servo_deg         = res_reg.servo_deg;
    assign throttle_now      = res_reg.throttle_now;
    assign steering_now      = res_reg.steering_now;
    assign drive_mode_out    = res_reg.drive_mode_out;
    assign emergency_latched = res_reg.emergency_latched;
    assign indicator_action  = res_reg.indicator_action;
    assign aeb_reset_request = res_reg.aeb_reset_request;
    assign cruise_override   = res_reg.cruise_override;

endmodule

/* hdl/dcsg_checker.sv */
// Port-level assertion checker for the drive command safety gate, with its bind.
`include "assert_macros.svh"

module dcsg_checker
    import dcsg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        motor_action,
    input logic [6:0]        motor_duty,
    input logic signed [7:0] throttle_now,
    input logic signed [7:0] steering_now,
    input logic              emergency_latched,
    input logic [1:0]        indicator_action,
    input logic              aeb_reset_request
);

    // a duty only comes with a forward or backward drive
    `DCSG_ASSERT_NOW(a_duty_needs_drive, out_valid && (motor_duty != 7'd0), (motor_action == ACT_FWD) || (motor_action == ACT_BACK), "motor duty without a drive action")

    // an alert is raised only together with the latch and a braked stop
    `DCSG_ASSERT_NOW(a_alert_latches, out_valid && (indicator_action == IND_ALERT), emergency_latched && (motor_action == ACT_STOP) && (throttle_now == 8'sd0), "alert without latch and stop")

    // releasing the braking latch only happens with the emergency latch clear
    `DCSG_ASSERT_NOW(a_release_clear, out_valid && aeb_reset_request, !emergency_latched && (indicator_action == IND_OFF), "release request while latched")

    // a stalled result holds
    `DCSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(motor_action) && $stable(throttle_now) && $stable(steering_now), "stalled result changed")

endmodule

bind drive_command_safety_gate dcsg_checker u_dcsg_checker (.*);
